FILE: sv/sdes_pkg.sv
// ----------------------------------------------------------------------------
// sdes_pkg
// Types, register indexes and S-DES permutation tables shared by the
// simplified DES CBC cipher core.
// ----------------------------------------------------------------------------
package sdes_pkg;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int KEY_W      = 10;
  localparam int ORDER_W    = 40;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 40;

  // Reset value of the P10 order: 3 5 2 7 4 10 1 9 8 6
  localparam logic [ORDER_W-1:0] KEY_ORDER_RST = 40'h35274A1986;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CIPHER_KEY   = 2'd0,
    REG_INIT_VECTOR  = 2'd1,
    REG_DECRYPT_MODE = 2'd2,
    REG_KEY_ORDER    = 2'd3
  } cfg_reg_t;

  // Input transaction payload
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_message;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_out;
  } out_item_t;

  // Round subkeys
  typedef struct packed {
    logic [BYTE_W-1:0] k1;
    logic [BYTE_W-1:0] k2;
  } subkeys_t;

  // Permutation tables, entries count bits from the MSB starting at 1
  localparam logic [3:0] IP_TAB  [8] = '{4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5, 4'd7};
  localparam logic [3:0] IPI_TAB [8] = '{4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8, 4'd6};
  localparam logic [3:0] EP_TAB  [8] = '{4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd1};
  localparam logic [3:0] P8_TAB  [8] = '{4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9};
  localparam logic [3:0] P4_TAB  [4] = '{4'd2, 4'd4, 4'd3, 4'd1};

  // S-boxes, indexed [row][col]
  localparam logic [1:0] SBOX_A [4][4] = '{
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd3, 2'd1, 2'd3, 2'd2}
  };
  localparam logic [1:0] SBOX_B [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3}
  };

  // P8 on a 10-bit word
  function automatic logic [7:0] perm_p8(logic [9:0] d);
    logic [7:0] res;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      res[3'(7 - i)] = d[4'(10 - int'(P8_TAB[i]))];
    end
    return res;
  endfunction

endpackage

FILE: sv/sdes_key_sched.sv
// ----------------------------------------------------------------------------
// sdes_key_sched
// Derives subkeys K1 and K2 from the key through the programmable P10
// order, the half rotations and P8.
// ----------------------------------------------------------------------------
module sdes_key_sched (
  input  logic [sdes_pkg::KEY_W-1:0]   cipher_key,
  input  logic [sdes_pkg::ORDER_W-1:0] key_order,
  output sdes_pkg::subkeys_t           subkeys
);

  logic [9:0] kp;
  logic [9:0] kp_rot1;
  logic [9:0] kp_rot3;

  // Rotate each five-bit half left by n
  function automatic logic [9:0] rot_halves(logic [9:0] k, int n);
    logic [4:0] hi;
    logic [4:0] lo;
    hi = k[9:5];
    lo = k[4:0];
    for (int i = 0; i < n; i++) begin
      hi = {hi[3:0], hi[4]};
      lo = {lo[3:0], lo[4]};
    end
    return {hi, lo};
  endfunction

  // Programmable P10: entry 1..10 picks key bit from the MSB, others give zero
  always_comb begin
    logic [3:0] e;
    kp = '0;
    for (int i = 0; i < 10; i++) begin
      e = key_order[(39 - 4 * i) -: 4];
      for (int j = 1; j <= 10; j++) begin
        if (e == 4'(j)) begin
          kp[4'(9 - i)] = cipher_key[4'(10 - j)];
        end
      end
    end
  end

  // Shifted keys and P8
  assign kp_rot1    = rot_halves(kp, 1);
  assign kp_rot3    = rot_halves(kp, 3);
  assign subkeys.k1 = sdes_pkg::perm_p8(kp_rot1);
  assign subkeys.k2 = sdes_pkg::perm_p8(kp_rot3);

endmodule

FILE: sv/sdes_block.sv
// ----------------------------------------------------------------------------
// sdes_block
// One S-DES block operation plus the CBC chaining xor, for encrypt or
// decrypt, and the next chain value.
// ----------------------------------------------------------------------------
module sdes_block (
  input  logic [sdes_pkg::BYTE_W-1:0] data_byte,
  input  logic                        end_of_message,
  input  logic [sdes_pkg::BYTE_W-1:0] chain_value,
  input  logic [sdes_pkg::BYTE_W-1:0] init_vector,
  input  logic                        decrypt_mode,
  input  sdes_pkg::subkeys_t          subkeys,
  output logic [sdes_pkg::BYTE_W-1:0] result_byte,
  output logic [sdes_pkg::BYTE_W-1:0] chain_nxt
);

  logic [7:0] blk_in;
  logic [7:0] key_a;
  logic [7:0] key_b;
  logic [7:0] x_ip;
  logic [7:0] x_r1;
  logic [7:0] x_sw;
  logic [7:0] x_r2;
  logic [7:0] blk_out;

  // Initial permutation
  function automatic logic [7:0] perm_ip(logic [7:0] d);
    logic [7:0] res;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      res[3'(7 - i)] = d[3'(8 - int'(sdes_pkg::IP_TAB[i]))];
    end
    return res;
  endfunction

  // Inverse initial permutation
  function automatic logic [7:0] perm_ipi(logic [7:0] d);
    logic [7:0] res;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      res[3'(7 - i)] = d[3'(8 - int'(sdes_pkg::IPI_TAB[i]))];
    end
    return res;
  endfunction

  // One Feistel round: L ^= P4(S(EP(R) ^ k))
  function automatic logic [7:0] round_fn(logic [7:0] x, logic [7:0] k);
    logic [7:0] t;
    logic [3:0] s;
    logic [3:0] p;
    t = '0;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      t[3'(7 - i)] = x[3'(4 - int'(sdes_pkg::EP_TAB[i]))];
    end
    t = t ^ k;
    s = {sdes_pkg::SBOX_A[{t[7], t[4]}][{t[6], t[5]}],
         sdes_pkg::SBOX_B[{t[3], t[0]}][{t[2], t[1]}]};
    for (int i = 0; i < 4; i++) begin
      p[2'(3 - i)] = s[2'(4 - int'(sdes_pkg::P4_TAB[i]))];
    end
    return {x[7:4] ^ p, x[3:0]};
  endfunction

  // Mode select: encrypt chains before the cipher, decrypt after it
  assign blk_in = decrypt_mode ? data_byte : (data_byte ^ chain_value);
  assign key_a  = decrypt_mode ? subkeys.k2 : subkeys.k1;
  assign key_b  = decrypt_mode ? subkeys.k1 : subkeys.k2;

  // Two rounds with a half swap between them
  assign x_ip    = perm_ip(blk_in);
  assign x_r1    = round_fn(x_ip, key_a);
  assign x_sw    = {x_r1[3:0], x_r1[7:4]};
  assign x_r2    = round_fn(x_sw, key_b);
  assign blk_out = perm_ipi(x_r2);

  assign result_byte = decrypt_mode ? (blk_out ^ chain_value) : blk_out;

  // Chain update, restarting at the IV after the last byte
  always_comb begin
    if (end_of_message) begin
      chain_nxt = init_vector;
    end else if (decrypt_mode) begin
      chain_nxt = data_byte;
    end else begin
      chain_nxt = result_byte;
    end
  end

endmodule

FILE: sv/sdes_cbc_cipher_core.sv
// ----------------------------------------------------------------------------
// sdes_cbc_cipher_core
// Simplified DES (10-bit key, 8-bit block) in CBC mode, one byte per
// transaction, with a programmable P10 key order.
// ----------------------------------------------------------------------------
// The input register holds each accepted byte until the result register
//   is free; the cipher logic then loads it there and out_valid rises.
// Throughput: one byte per cycle while out_ready stays high; the CBC chain
//   register closes its loop through the single cipher stage.
// Reset (synchronous, rst_n low): pipeline empty, key 0, IV 0, encrypt mode,
//   standard P10 order, chain value 0.
module sdes_cbc_cipher_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [sdes_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sdes_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sdes_pkg::in_item_t               in_data,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output sdes_pkg::out_item_t              out_data
);

  // Configuration registers and chain
  logic [sdes_pkg::KEY_W-1:0]   cipher_key_r;
  logic [sdes_pkg::BYTE_W-1:0]  init_vector_r;
  logic                         decrypt_mode_r;
  logic [sdes_pkg::ORDER_W-1:0] key_order_r;
  logic [sdes_pkg::BYTE_W-1:0]  chain_r;
  logic [sdes_pkg::BYTE_W-1:0]  chain_nxt;

  // Pipeline registers
  logic                         in_valid_r;
  sdes_pkg::in_item_t           in_item_r;
  logic                         out_valid_r;
  sdes_pkg::out_item_t          out_item_r;

  sdes_pkg::subkeys_t           subkeys;
  logic [sdes_pkg::BYTE_W-1:0]  result_byte;
  logic                         advance;
  logic                         in_take;

  // Handshake: the held item moves on when the result register is free
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign in_take   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_key_r   <= '0;
      init_vector_r  <= '0;
      decrypt_mode_r <= 1'b0;
      key_order_r    <= sdes_pkg::KEY_ORDER_RST;
    end else if (cfg_we) begin
      unique case (sdes_pkg::cfg_reg_t'(cfg_addr))
        sdes_pkg::REG_CIPHER_KEY:   cipher_key_r   <= cfg_wdata[sdes_pkg::KEY_W-1:0];
        sdes_pkg::REG_INIT_VECTOR:  init_vector_r  <= cfg_wdata[sdes_pkg::BYTE_W-1:0];
        sdes_pkg::REG_DECRYPT_MODE: decrypt_mode_r <= cfg_wdata[0];
        sdes_pkg::REG_KEY_ORDER:    key_order_r    <= cfg_wdata[sdes_pkg::ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // Chain value: IV write restarts the chain, otherwise follows each byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else if (cfg_we && (sdes_pkg::cfg_reg_t'(cfg_addr) == sdes_pkg::REG_INIT_VECTOR)) begin
      chain_r <= cfg_wdata[sdes_pkg::BYTE_W-1:0];
    end else if (advance) begin
      chain_r <= chain_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
  end

  // Subkey derivation
  sdes_key_sched u_key_sched (
    .cipher_key (cipher_key_r),
    .key_order  (key_order_r),
    .subkeys    (subkeys)
  );

  // Cipher and chaining
  sdes_block u_block (
    .data_byte      (in_item_r.data_byte),
    .end_of_message (in_item_r.end_of_message),
    .chain_value    (chain_r),
    .init_vector    (init_vector_r),
    .decrypt_mode   (decrypt_mode_r),
    .subkeys        (subkeys),
    .result_byte    (result_byte),
    .chain_nxt      (chain_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r.out_byte <= result_byte;
      out_item_r.last_out <= in_item_r.end_of_message;
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the S-DES CBC cipher core. A queue of bytes,
// grouped into messages, is sent through a valid/ready driver with random
// gaps. A local S-DES/CBC predictor computes each expected result when the
// input transaction is accepted. The monitor compares every result with
// the oldest prediction. Register writes happen between phases while the
// core is drained.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 6;
  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 150;
  localparam int TARGET_ITEMS = 950;
  localparam int REPORT_MAX   = 10;

  // Permutation tables, entries number bits from the MSB starting at 1
  typedef int perm_tab_t [8];
  localparam perm_tab_t INIT_PERM  = '{2, 6, 3, 1, 4, 8, 5, 7};
  localparam perm_tab_t FINAL_PERM = '{4, 1, 3, 5, 7, 2, 8, 6};
  localparam perm_tab_t EXPAND     = '{4, 1, 2, 3, 2, 3, 4, 1};
  localparam perm_tab_t KEY_SELECT = '{6, 3, 7, 4, 8, 5, 10, 9};
  localparam perm_tab_t ROUND_PERM = '{2, 4, 3, 1, 0, 0, 0, 0};

  localparam logic [1:0] SUB_LEFT [4][4] = '{
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd2, 2'd1, 2'd3},
    '{2'd3, 2'd1, 2'd3, 2'd2}
  };
  localparam logic [1:0] SUB_RIGHT [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd3}
  };

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [sdes_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [sdes_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            in_valid;
  logic                            in_ready;
  sdes_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_ready;
  sdes_pkg::out_item_t             out_data;

  sdes_cbc_cipher_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Predictor copy of the registers and the chain
  logic [sdes_pkg::KEY_W-1:0]   key_reg;
  logic [7:0]                   iv_reg;
  logic                         decrypt_reg;
  logic [sdes_pkg::ORDER_W-1:0] order_reg;
  logic [7:0]                   chain_byte;

  sdes_pkg::in_item_t  bytes_to_send[$];
  sdes_pkg::out_item_t cipher_expected[$];

  int  fail_cnt;
  int  idle_cycles;
  int  items_queued;
  bit  offer_done;
  int  send_gap;
  bit  sender_steady;
  bit  receiver_steady;
  int  hold_requests;
  int  holds_started;
  int  ready_stall;

  // --------------------------------------------------------------------------
  // S-DES predictor
  // --------------------------------------------------------------------------
  function automatic logic [9:0] permute_bits(logic [9:0] d, int n_in, int n_out,
                                              perm_tab_t tab);
    logic [9:0] r;
    r = '0;
    for (int i = 0; i < n_out; i++) begin
      r[n_out - 1 - i] = d[n_in - tab[i]];
    end
    return r;
  endfunction

  // rotate each five-bit half left by n
  function automatic logic [9:0] rotate_halves(logic [9:0] k, int n);
    logic [4:0] hi;
    logic [4:0] lo;
    hi = k[9:5];
    lo = k[4:0];
    for (int i = 0; i < n; i++) begin
      hi = {hi[3:0], hi[4]};
      lo = {lo[3:0], lo[4]};
    end
    return {hi, lo};
  endfunction

  function automatic sdes_pkg::subkeys_t derive_subkeys(logic [sdes_pkg::KEY_W-1:0] key,
                                                        logic [sdes_pkg::ORDER_W-1:0] order);
    logic [9:0]         kp;
    logic [3:0]         ent;
    sdes_pkg::subkeys_t sk;
    kp = '0;
    for (int i = 0; i < 10; i++) begin
      ent = order[39 - 4 * i -: 4];
      // out-of-range table entries select a zero bit
      if (ent >= 4'd1 && ent <= 4'd10) kp[9 - i] = key[10 - int'(ent)];
    end
    sk.k1 = 8'(permute_bits(rotate_halves(kp, 1), 10, 8, KEY_SELECT));
    sk.k2 = 8'(permute_bits(rotate_halves(kp, 3), 10, 8, KEY_SELECT));
    return sk;
  endfunction

  function automatic logic [7:0] feistel_round(logic [7:0] x, logic [7:0] k);
    logic [7:0] t;
    logic [3:0] s;
    logic [3:0] l;
    t = 8'(permute_bits({6'd0, x[3:0]}, 4, 8, EXPAND)) ^ k;
    s = {SUB_LEFT[{t[7], t[4]}][{t[6], t[5]}], SUB_RIGHT[{t[3], t[0]}][{t[2], t[1]}]};
    l = x[7:4] ^ 4'(permute_bits({6'd0, s}, 4, 4, ROUND_PERM));
    return {l, x[3:0]};
  endfunction

  function automatic logic [7:0] sdes_block(logic [7:0] x, logic [7:0] ka, logic [7:0] kb);
    logic [7:0] v;
    v = 8'(permute_bits({2'd0, x}, 8, 8, INIT_PERM));
    v = feistel_round(v, ka);
    v = {v[3:0], v[7:4]};
    v = feistel_round(v, kb);
    return 8'(permute_bits({2'd0, v}, 8, 8, FINAL_PERM));
  endfunction

  // One CBC step: returns the result and advances the chain
  function automatic sdes_pkg::out_item_t cbc_step(sdes_pkg::in_item_t item);
    sdes_pkg::subkeys_t  sk;
    sdes_pkg::out_item_t res;
    sk = derive_subkeys(key_reg, order_reg);
    if (decrypt_reg) begin
      res.out_byte = sdes_block(item.data_byte, sk.k2, sk.k1) ^ chain_byte;
      chain_byte   = item.data_byte;
    end else begin
      res.out_byte = sdes_block(item.data_byte ^ chain_byte, sk.k1, sk.k2);
      chain_byte   = res.out_byte;
    end
    if (item.end_of_message) chain_byte = iv_reg;
    res.last_out = item.end_of_message;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(HALF_PERIOD) clk = ~clk;
  end

  // Gap length: mostly zero or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: offers the head of the byte queue
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    logic nxt_valid;
    nxt_valid = in_valid;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && offer_done) begin
        nxt_valid = 1'b0;
        send_gap  = sender_steady ? 0 : pick_gap();
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (bytes_to_send.size() > 0) begin
          in_data   <= bytes_to_send[0];
          nxt_valid = 1'b1;
        end
      end
    end
    offer_done = 1'b0;
    in_valid <= nxt_valid;
  end

  // Accepted input transaction: predict its result
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      cipher_expected.push_back(cbc_step(in_data));
      void'(bytes_to_send.pop_front());
      offer_done = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: ready pattern with random stalls and one-off long holds
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (holds_started != hold_requests) begin
        holds_started = hold_requests;
        ready_stall   = LONG_HOLD;
      end
      if (ready_stall > 0) begin
        ready_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!receiver_steady && $urandom_range(0, 3) == 0) ready_stall = pick_gap();
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    sdes_pkg::out_item_t exp_item;
    if (rst_n && out_valid && out_ready) begin
      if (cipher_expected.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX)
          $display("%0t: unexpected result byte=%h last=%b", $realtime,
                   out_data.out_byte, out_data.last_out);
      end else begin
        exp_item = cipher_expected.pop_front();
        if (out_data.out_byte !== exp_item.out_byte ||
            out_data.last_out !== exp_item.last_out) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("%0t: mismatch byte exp=%h got=%h, last exp=%b got=%b", $realtime,
                     exp_item.out_byte, out_data.out_byte, exp_item.last_out,
                     out_data.last_out);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic cfg_write(sdes_pkg::cfg_reg_t idx, logic [sdes_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      sdes_pkg::REG_CIPHER_KEY:   key_reg = val[sdes_pkg::KEY_W-1:0];
      sdes_pkg::REG_INIT_VECTOR: begin
        iv_reg     = val[7:0];
        chain_byte = val[7:0];
      end
      sdes_pkg::REG_DECRYPT_MODE: decrypt_reg = val[0];
      sdes_pkg::REG_KEY_ORDER:    order_reg = val[sdes_pkg::ORDER_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_byte(logic [7:0] b, logic last);
    sdes_pkg::in_item_t item;
    item.data_byte      = b;
    item.end_of_message = last;
    bytes_to_send.push_back(item);
    items_queued++;
  endtask

  // wait until every queued byte is accepted and every result has arrived
  task automatic drain();
    while (bytes_to_send.size() > 0 || cipher_expected.size() > 0) @(posedge clk);
  endtask

  // random valid P10 ordering of 1..10
  function automatic logic [sdes_pkg::ORDER_W-1:0] shuffled_order();
    int perm [10];
    int j;
    int t;
    logic [sdes_pkg::ORDER_W-1:0] packed_order;
    for (int i = 0; i < 10; i++) perm[i] = i + 1;
    for (int i = 9; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    packed_order = '0;
    for (int i = 0; i < 10; i++) packed_order = {packed_order[35:0], 4'(perm[i])};
    return packed_order;
  endfunction

  task automatic random_config();
    int r;
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 7);
      cfg_write(sdes_pkg::REG_CIPHER_KEY,
                (r == 0) ? 40'd0 : (r == 1) ? 40'd1023 : 40'($urandom_range(0, 1023)));
    end
    if ($urandom_range(0, 1)) begin
      r = $urandom_range(0, 7);
      cfg_write(sdes_pkg::REG_INIT_VECTOR,
                (r == 0) ? 40'd0 : (r == 1) ? 40'd255 : 40'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1)) cfg_write(sdes_pkg::REG_DECRYPT_MODE, 40'($urandom_range(0, 1)));
    if ($urandom_range(0, 2) == 0) begin
      r = $urandom_range(0, 9);
      if (r == 0)      cfg_write(sdes_pkg::REG_KEY_ORDER, '0);
      else if (r == 1) cfg_write(sdes_pkg::REG_KEY_ORDER, '1);
      else if (r == 2) cfg_write(sdes_pkg::REG_KEY_ORDER, 40'({$urandom(), $urandom()}));
      else             cfg_write(sdes_pkg::REG_KEY_ORDER, shuffled_order());
    end
    cfg_release();
  endtask

  // messages with random content; the last one may be left open
  task automatic queue_messages(int n_bytes);
    int len;
    bit close_it;
    while (n_bytes > 0) begin
      len      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      if (len > n_bytes) len = n_bytes;
      n_bytes -= len;
      close_it = (n_bytes > 0) || ($urandom_range(0, 2) != 0);
      for (int i = 0; i < len; i++) queue_byte(8'($urandom_range(0, 255)), close_it && (i == len - 1));
    end
  endtask

  initial begin
    int phase_no;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_addr        = '0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_ready       = 1'b0;
    fail_cnt        = 0;
    idle_cycles     = 0;
    items_queued    = 0;
    offer_done      = 1'b0;
    send_gap        = 0;
    sender_steady   = 1'b1;
    receiver_steady = 1'b1;
    hold_requests   = 0;
    holds_started   = 0;
    ready_stall     = 0;
    key_reg         = '0;
    iv_reg          = '0;
    decrypt_reg     = 1'b0;
    order_reg       = sdes_pkg::KEY_ORDER_RST;
    chain_byte      = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero key, standard order, encrypt, chain across last
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hA5, 1'b1);
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'h00, 1'b1);
    drain();

    // All-ones key and IV, decrypt, order with out-of-range entries
    cfg_write(sdes_pkg::REG_CIPHER_KEY, 40'h3FF);
    cfg_write(sdes_pkg::REG_INIT_VECTOR, 40'hFF);
    cfg_write(sdes_pkg::REG_DECRYPT_MODE, 40'd1);
    cfg_write(sdes_pkg::REG_KEY_ORDER, 40'h0BCDEF1234);
    cfg_release();
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b1);
    queue_byte(8'h01, 1'b0);
    drain();

    // Key and mode change in the middle of a message
    cfg_write(sdes_pkg::REG_DECRYPT_MODE, 40'd0);
    cfg_write(sdes_pkg::REG_CIPHER_KEY, 40'h155);
    cfg_write(sdes_pkg::REG_KEY_ORDER, sdes_pkg::KEY_ORDER_RST);
    cfg_release();
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hC3, 1'b0);
    queue_byte(8'h3C, 1'b0);
    drain();

    // IV rewrite restarts the chain mid-message
    cfg_write(sdes_pkg::REG_INIT_VECTOR, 40'h3C);
    cfg_release();
    queue_byte(8'h11, 1'b0);
    queue_byte(8'hEE, 1'b0);
    queue_byte(8'h42, 1'b1);
    drain();

    // Key order extremes
    cfg_write(sdes_pkg::REG_KEY_ORDER, '1);
    cfg_release();
    queue_byte(8'h96, 1'b0);
    queue_byte(8'h69, 1'b1);
    drain();
    cfg_write(sdes_pkg::REG_KEY_ORDER, '0);
    cfg_write(sdes_pkg::REG_CIPHER_KEY, 40'h000);
    cfg_write(sdes_pkg::REG_INIT_VECTOR, 40'h00);
    cfg_release();
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h80, 1'b1);
    drain();

    // Random phases; the first ones block the result side for a long stretch
    phase_no = 0;
    while (items_queued < TARGET_ITEMS) begin
      random_config();
      sender_steady   = (phase_no < 2) || ($urandom_range(0, 3) == 0);
      receiver_steady = ($urandom_range(0, 3) == 0);
      if (phase_no < 2) hold_requests++;
      queue_messages($urandom_range(40, 90));
      drain();
      phase_no++;
    end

    repeat (10) @(posedge clk);
    if (fail_cnt == 0 && cipher_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
